// ----- sv/scoped_symbol_stack_defines.svh -----
// ----------------------------------------------------------------------------
// Scoped symbol stack assertion macros
// Concurrent assertion forms used by the symbol stack sequencer.
// ----------------------------------------------------------------------------
`ifndef SCOPED_SYMBOL_STACK_DEFINES_SVH
`define SCOPED_SYMBOL_STACK_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SSS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/sss_pkg.sv -----
// ----------------------------------------------------------------------------
// Scoped symbol stack package
// Sizes, request and status codes, and the memory access bundles.
// ----------------------------------------------------------------------------
package sss_pkg;

	localparam int ENTRY_DEPTH = 64;
	localparam int SCOPE_DEPTH = 16;
	localparam int KEY_BITS    = 64;

	// Port field widths.
	localparam int REQ_W    = 3;
	localparam int KEY_W    = 64;
	localparam int KIND_W   = 8;
	localparam int INDEX_W  = 6;
	localparam int STATUS_W = 2;

	// Derived storage widths.
	localparam int EIDX_W = $clog2(ENTRY_DEPTH);
	localparam int ECNT_W = $clog2(ENTRY_DEPTH + 1);
	localparam int SIDX_W = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
	localparam int SCNT_W = $clog2(SCOPE_DEPTH + 1);

	localparam logic [REQ_W-1:0] REQ_OPEN     = REQ_W'(0);
	localparam logic [REQ_W-1:0] REQ_REGISTER = REQ_W'(1);
	localparam logic [REQ_W-1:0] REQ_LOOKUP   = REQ_W'(2);
	localparam logic [REQ_W-1:0] REQ_POP      = REQ_W'(3);
	localparam logic [REQ_W-1:0] REQ_WIPE     = REQ_W'(4);

	localparam logic [STATUS_W-1:0] ST_OK         = STATUS_W'(0);
	localparam logic [STATUS_W-1:0] ST_ENTRY_FULL = STATUS_W'(1);
	localparam logic [STATUS_W-1:0] ST_SCOPE_FULL = STATUS_W'(2);
	localparam logic [STATUS_W-1:0] ST_NO_SCOPE   = STATUS_W'(3);

	typedef struct packed {
		logic                we;
		logic [EIDX_W-1:0]   waddr;
		logic [KEY_BITS-1:0] wkey;
		logic [KIND_W-1:0]   wkind;
		logic [EIDX_W-1:0]   raddr;
	} entry_req_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic [KIND_W-1:0]   kind;
	} entry_rd_t;

	typedef struct packed {
		logic              we;
		logic [SIDX_W-1:0] waddr;
		logic [ECNT_W-1:0] wdata;
		logic [SIDX_W-1:0] raddr;
	} scope_req_t;

endpackage

// ----- sv/scoped_symbol_stack.sv -----
// ----------------------------------------------------------------------------
// Scoped symbol stack
// Symbol table kept as an entry stack plus a stack of per-scope entry counts.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single result
// appears on the registered done strobe for exactly one cycle and cannot be
// held off. Open scope, wipe, ignored codes and any rejected request are
// resolved in the idle state. Register and pop scope read the scope size from
// its memory and write it back or apply it in the following cycle. A lookup
// examines entries newest first, one entry memory read per cycle, up to all 64
// on a full stack. Scope sizes saturate at the entry stack depth. No clearing
// pass is needed after reset; busy is low as soon as reset is released.
module scoped_symbol_stack (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [sss_pkg::REQ_W-1:0]      req_type,
	input  logic [sss_pkg::KEY_W-1:0]      symbol_key,
	input  logic [sss_pkg::KIND_W-1:0]     symbol_kind,
	output logic                           done,
	output logic                           found,
	output logic [sss_pkg::INDEX_W-1:0]    entry_index,
	output logic [sss_pkg::KIND_W-1:0]     found_kind,
	output logic [sss_pkg::STATUS_W-1:0]   status
);

	sss_pkg::entry_req_t         ereq;
	sss_pkg::entry_rd_t          erd;
	sss_pkg::scope_req_t         sreq;
	logic [sss_pkg::ECNT_W-1:0]  scope_rdata;

	sss_entry_ram u_entry_ram (
		.clk (clk),
		.req (ereq),
		.rd  (erd)
	);

	sss_scope_ram u_scope_ram (
		.clk   (clk),
		.req   (sreq),
		.rdata (scope_rdata)
	);

	sss_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.symbol_key  (symbol_key),
		.symbol_kind (symbol_kind),
		.ereq        (ereq),
		.erd         (erd),
		.sreq        (sreq),
		.scope_rdata (scope_rdata),
		.done        (done),
		.found       (found),
		.entry_index (entry_index),
		.found_kind  (found_kind),
		.status      (status)
	);

endmodule

// ----- sv/sss_entry_ram.sv -----
// ----------------------------------------------------------------------------
// Symbol entry memory
// Key and kind storage for the entry stack; one write and one registered read.
// ----------------------------------------------------------------------------
module sss_entry_ram (
	input  logic                clk,
	input  sss_pkg::entry_req_t req,
	output sss_pkg::entry_rd_t  rd
);

	logic [sss_pkg::KEY_BITS-1:0] keys  [sss_pkg::ENTRY_DEPTH];
	logic [sss_pkg::KIND_W-1:0]   kinds [sss_pkg::ENTRY_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			keys[req.waddr]  <= req.wkey;
			kinds[req.waddr] <= req.wkind;
		end
		rd.key  <= keys[req.raddr];
		rd.kind <= kinds[req.raddr];
	end

endmodule

// ----- sv/sss_scope_ram.sv -----
// ----------------------------------------------------------------------------
// Scope size memory
// Per-scope entry counts; one write and one registered read.
// ----------------------------------------------------------------------------
module sss_scope_ram (
	input  logic                        clk,
	input  sss_pkg::scope_req_t         req,
	output logic [sss_pkg::ECNT_W-1:0]  rdata
);

	logic [sss_pkg::ECNT_W-1:0] sizes [sss_pkg::SCOPE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			sizes[req.waddr] <= req.wdata;
		end
		rdata <= sizes[req.raddr];
	end

endmodule

// ----- sv/sss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Scoped symbol stack sequencer
// Decodes requests, keeps the stack pointers and walks the entry memory.
// ----------------------------------------------------------------------------
`include "scoped_symbol_stack_defines.svh"

module sss_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [sss_pkg::REQ_W-1:0]      req_type,
	input  logic [sss_pkg::KEY_W-1:0]      symbol_key,
	input  logic [sss_pkg::KIND_W-1:0]     symbol_kind,
	output sss_pkg::entry_req_t            ereq,
	input  sss_pkg::entry_rd_t             erd,
	output sss_pkg::scope_req_t            sreq,
	input  logic [sss_pkg::ECNT_W-1:0]     scope_rdata,
	output logic                           done,
	output logic                           found,
	output logic [sss_pkg::INDEX_W-1:0]    entry_index,
	output logic [sss_pkg::KIND_W-1:0]     found_kind,
	output logic [sss_pkg::STATUS_W-1:0]   status
);

	localparam logic [1:0] ST_IDLE    = 2'd0;
	localparam logic [1:0] ST_REG_RMW = 2'd1;
	localparam logic [1:0] ST_LOOK    = 2'd2;
	localparam logic [1:0] ST_POP_RD  = 2'd3;

	logic [1:0]                     state_q, state_d;
	logic [sss_pkg::ECNT_W-1:0]     count_q, count_d, cnt_m1, sat_inc;
	logic [sss_pkg::SCNT_W-1:0]     depth_q, depth_d, dep_m1;
	logic [sss_pkg::EIDX_W-1:0]     idx_q, idx_d;
	logic [sss_pkg::KEY_BITS-1:0]   key_q, key_d;
	logic                           accept;

	logic                           done_q, done_d;
	logic                           found_q, found_d;
	logic [sss_pkg::EIDX_W-1:0]     index_q, index_d;
	logic [sss_pkg::KIND_W-1:0]     fkind_q, fkind_d;
	logic [sss_pkg::STATUS_W-1:0]   status_q, status_d;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign cnt_m1 = count_q - sss_pkg::ECNT_W'(1);
	assign dep_m1 = depth_q - sss_pkg::SCNT_W'(1);

	// A scope can outgrow the entry stack across wipes; any size at or above
	// the stack depth pops everything, so the count saturates there.
	assign sat_inc = (scope_rdata >= sss_pkg::ECNT_W'(sss_pkg::ENTRY_DEPTH)) ?
		scope_rdata : scope_rdata + sss_pkg::ECNT_W'(1);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		depth_d  = depth_q;
		idx_d    = idx_q;
		key_d    = key_q;
		done_d   = 1'b0;
		found_d  = 1'b0;
		index_d  = '0;
		fkind_d  = '0;
		status_d = sss_pkg::ST_OK;

		ereq.we    = 1'b0;
		ereq.waddr = count_q[sss_pkg::EIDX_W-1:0];
		ereq.wkey  = symbol_key[sss_pkg::KEY_BITS-1:0];
		ereq.wkind = symbol_kind;
		ereq.raddr = (state_q == ST_LOOK) ? idx_q - sss_pkg::EIDX_W'(1) :
			cnt_m1[sss_pkg::EIDX_W-1:0];

		sreq.we    = 1'b0;
		sreq.waddr = depth_q[sss_pkg::SIDX_W-1:0];
		sreq.wdata = '0;
		sreq.raddr = dep_m1[sss_pkg::SIDX_W-1:0];

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					key_d = symbol_key[sss_pkg::KEY_BITS-1:0];
					unique case (req_type)
						sss_pkg::REQ_OPEN: begin
							done_d = 1'b1;
							if (depth_q >= sss_pkg::SCNT_W'(sss_pkg::SCOPE_DEPTH)) begin
								status_d = sss_pkg::ST_SCOPE_FULL;
							end else begin
								sreq.we = 1'b1;
								depth_d = depth_q + sss_pkg::SCNT_W'(1);
							end
						end
						sss_pkg::REQ_REGISTER: begin
							if (depth_q == '0) begin
								done_d   = 1'b1;
								status_d = sss_pkg::ST_NO_SCOPE;
							end else if (count_q >= sss_pkg::ECNT_W'(sss_pkg::ENTRY_DEPTH)) begin
								done_d   = 1'b1;
								status_d = sss_pkg::ST_ENTRY_FULL;
							end else begin
								// The scope size read goes out now; it is bumped next cycle.
								ereq.we = 1'b1;
								count_d = count_q + sss_pkg::ECNT_W'(1);
								state_d = ST_REG_RMW;
							end
						end
						sss_pkg::REQ_LOOKUP: begin
							if (count_q == '0) begin
								done_d = 1'b1;
							end else begin
								idx_d   = cnt_m1[sss_pkg::EIDX_W-1:0];
								state_d = ST_LOOK;
							end
						end
						sss_pkg::REQ_POP: begin
							if (depth_q == '0) begin
								done_d   = 1'b1;
								status_d = sss_pkg::ST_NO_SCOPE;
							end else begin
								state_d = ST_POP_RD;
							end
						end
						sss_pkg::REQ_WIPE: begin
							done_d  = 1'b1;
							count_d = '0;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_REG_RMW: begin
				sreq.we    = 1'b1;
				sreq.waddr = dep_m1[sss_pkg::SIDX_W-1:0];
				sreq.wdata = sat_inc;
				done_d     = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_LOOK: begin
				// The read data belongs to idx_q; the next older entry is being read.
				if (erd.key == key_q) begin
					done_d  = 1'b1;
					found_d = 1'b1;
					index_d = idx_q;
					fkind_d = erd.kind;
					state_d = ST_IDLE;
				end else if (idx_q == '0) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					idx_d = idx_q - sss_pkg::EIDX_W'(1);
				end
			end
			ST_POP_RD: begin
				count_d = (scope_rdata >= count_q) ? '0 : count_q - scope_rdata;
				depth_d = dep_m1;
				done_d  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			depth_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			depth_q <= depth_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		key_q    <= key_d;
		found_q  <= found_d;
		index_q  <= index_d;
		fkind_q  <= fkind_d;
		status_q <= status_d;
	end

	assign done        = done_q;
	assign found       = found_q;
	assign entry_index = sss_pkg::INDEX_W'(index_q);
	assign found_kind  = fkind_q;
	assign status      = status_q;

	`SSS_ASSERT_NOW(a_count_bound, 1'b1,
		count_q <= sss_pkg::ECNT_W'(sss_pkg::ENTRY_DEPTH), "entry count beyond stack depth")
	`SSS_ASSERT_NOW(a_depth_bound, 1'b1,
		depth_q <= sss_pkg::SCNT_W'(sss_pkg::SCOPE_DEPTH), "scope depth beyond stack depth")
	`SSS_ASSERT_NOW(a_done_idle, done_q, state_q == ST_IDLE,
		"result strobe while a request is still in progress")
	`SSS_ASSERT_NOW(a_hit_in_range, done_q && found_q,
		sss_pkg::ECNT_W'(index_q) < count_q, "lookup hit outside the stored entries")
	`SSS_ASSERT_NEXT(a_register_push,
		accept && req_type == sss_pkg::REQ_REGISTER && depth_q != '0 &&
		count_q < sss_pkg::ECNT_W'(sss_pkg::ENTRY_DEPTH),
		state_q == ST_REG_RMW && count_q == $past(count_q) + sss_pkg::ECNT_W'(1),
		"register transaction did not push an entry")

endmodule

// ----- dv/scoped_symbol_stack_tb.sv -----
// ----------------------------------------------------------------------------
// Scoped symbol stack testbench
// Drives open, register, lookup, pop and wipe transactions through the
// start/busy handshake and checks every done strobe against a local model
// of the entry and scope stacks. Edge cases come first, then random traffic.
// ----------------------------------------------------------------------------
module scoped_symbol_stack_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sss_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 2 * ENTRY_DEPTH + 8;
	localparam int MAX_SHOWN      = 10;
	localparam int POOL_SIZE      = 8;

	localparam logic [REQ_W-1:0] REQ_SPARE_LO = REQ_WIPE + REQ_W'(1);
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = {REQ_W{1'b1}};
	localparam logic [KEY_W-1:0] KEY_MASK     = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

	typedef struct packed {
		logic                hit;
		logic [INDEX_W-1:0]  idx;
		logic [KIND_W-1:0]   kind;
		logic [STATUS_W-1:0] st;
	} outcome_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                start       = 1'b0;
	logic                busy;
	logic [REQ_W-1:0]    req_type    = '0;
	logic [KEY_W-1:0]    symbol_key  = '0;
	logic [KIND_W-1:0]   symbol_kind = '0;
	logic                done;
	logic                found;
	logic [INDEX_W-1:0]  entry_index;
	logic [KIND_W-1:0]   found_kind;
	logic [STATUS_W-1:0] status;

	// Model of the symbol table.
	logic [KEY_W-1:0]  sym_keys  [ENTRY_DEPTH];
	logic [KIND_W-1:0] sym_kinds [ENTRY_DEPTH];
	int                scope_sizes [SCOPE_DEPTH];
	int                sym_count   = 0;
	int                scope_level = 0;

	outcome_t          pending_outcomes [$];
	logic [KEY_W-1:0]  key_pool [POOL_SIZE];

	int mismatch_count = 0;
	int error_count    = 0;
	int sent_count     = 0;
	int checked_count  = 0;
	int lookup_hits    = 0;
	int status_seen [4];
	int peak_entries   = 0;
	int peak_scopes    = 0;
	int burst_left     = 0;
	int quiet_cycles   = 0;

	scoped_symbol_stack dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.symbol_key  (symbol_key),
		.symbol_kind (symbol_kind),
		.done        (done),
		.found       (found),
		.entry_index (entry_index),
		.found_kind  (found_kind),
		.status      (status)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Applies one request to the model and returns the result it must produce.
	function automatic outcome_t resolve_request(input logic [REQ_W-1:0] req,
			input logic [KEY_W-1:0] key, input logic [KIND_W-1:0] kind);
		outcome_t r;
		int       n;
		r = '0;
		case (req)
			REQ_OPEN: begin
				if (scope_level >= SCOPE_DEPTH) begin
					r.st = ST_SCOPE_FULL;
				end else begin
					scope_sizes[scope_level] = 0;
					scope_level++;
				end
			end
			REQ_REGISTER: begin
				if (scope_level == 0) begin
					r.st = ST_NO_SCOPE;
				end else if (sym_count >= ENTRY_DEPTH) begin
					r.st = ST_ENTRY_FULL;
				end else begin
					sym_keys[sym_count]  = key & KEY_MASK;
					sym_kinds[sym_count] = kind;
					sym_count++;
					scope_sizes[scope_level-1]++;
				end
			end
			REQ_LOOKUP: begin
				n = sym_count;
				while (n > 0 && !r.hit) begin
					n--;
					if (sym_keys[n] == (key & KEY_MASK)) begin
						r.hit  = 1'b1;
						r.idx  = INDEX_W'(n);
						r.kind = sym_kinds[n];
					end
				end
			end
			REQ_POP: begin
				if (scope_level == 0) begin
					r.st = ST_NO_SCOPE;
				end else begin
					n         = scope_sizes[scope_level-1];
					sym_count = (n >= sym_count) ? 0 : sym_count - n;
					scope_level--;
				end
			end
			REQ_WIPE: sym_count = 0;
			default: ;
		endcase
		if (sym_count > peak_entries) peak_entries = sym_count;
		if (scope_level > peak_scopes) peak_scopes = scope_level;
		return r;
	endfunction

	// Presents one request and holds it until the block takes it. Start is
	// left high so that the caller either sends again or idles in this step.
	task automatic send_request(input logic [REQ_W-1:0] req,
			input logic [KEY_W-1:0] key, input logic [KIND_W-1:0] kind);
		start       <= 1'b1;
		req_type    <= req;
		symbol_key  <= key;
		symbol_kind <= kind;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_outcomes.push_back(resolve_request(req, key, kind));
		sent_count++;
	endtask

	task automatic idle_cycles(input int n);
		start       <= 1'b0;
		req_type    <= REQ_W'($urandom_range(0, 7));
		symbol_key  <= {$urandom, $urandom};
		symbol_kind <= KIND_W'($urandom);
		repeat (n) @(posedge clk);
	endtask

	// Sends in bursts; most bursts are short, some run long without a gap.
	task automatic issue(input logic [REQ_W-1:0] req,
			input logic [KEY_W-1:0] key, input logic [KIND_W-1:0] kind);
		send_request(req, key, kind);
		burst_left--;
		if (burst_left <= 0) begin
			idle_cycles($urandom_range(1, 8));
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
		end
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
		return {$urandom, $urandom};
	endfunction

	task automatic test_edge_requests();
		issue(REQ_REGISTER, {KEY_W{1'b1}}, 8'hFF);
		issue(REQ_POP, '0, '0);
		issue(REQ_LOOKUP, '0, '0);
		issue(REQ_WIPE, '0, '0);
		for (int r = REQ_SPARE_LO; r <= REQ_SPARE_HI; r++)
			issue(REQ_W'(r), {$urandom, $urandom}, KIND_W'($urandom));
		issue(REQ_OPEN, '0, '0);
		issue(REQ_REGISTER, {KEY_W{1'b1}}, 8'hFF);
		issue(REQ_REGISTER, '0, '0);
		issue(REQ_REGISTER, {KEY_W{1'b1}}, 8'h5A);
		issue(REQ_LOOKUP, {KEY_W{1'b1}}, '0);
		issue(REQ_LOOKUP, '0, 8'hFF);
		issue(REQ_LOOKUP, {(KEY_W/2){2'b01}}, '0);
		issue(REQ_OPEN, '0, '0);
		issue(REQ_REGISTER, {1'b1, {(KEY_W-2){1'b0}}, 1'b1}, 8'h80);
		issue(REQ_POP, '0, '0);
		issue(REQ_LOOKUP, {1'b1, {(KEY_W-2){1'b0}}, 1'b1}, '0);
		// After a wipe the outer scope still claims three entries.
		issue(REQ_WIPE, '0, '0);
		issue(REQ_LOOKUP, {KEY_W{1'b1}}, '0);
		issue(REQ_POP, '0, '0);
		issue(REQ_POP, '0, '0);
		wait_all_results();
	endtask

	task automatic test_scope_limits();
		for (int i = 0; i <= SCOPE_DEPTH; i++) issue(REQ_OPEN, '0, '0);
		issue(REQ_REGISTER, key_pool[0], 8'h11);
		issue(REQ_LOOKUP, key_pool[0], '0);
		for (int i = 0; i <= SCOPE_DEPTH; i++) issue(REQ_POP, '0, '0);
		wait_all_results();
	endtask

	task automatic test_entry_limits();
		logic [KEY_W-1:0] oldest;
		logic [KEY_W-1:0] k;
		oldest = '0;
		issue(REQ_OPEN, '0, '0);
		for (int i = 0; i <= ENTRY_DEPTH; i++) begin
			k = {$urandom, $urandom};
			if (i == 0) oldest = k;
			issue(REQ_REGISTER, k, KIND_W'($urandom));
		end
		// The oldest entry and a missing key both make the search walk the full stack.
		issue(REQ_LOOKUP, oldest, '0);
		issue(REQ_LOOKUP, k, '0);
		issue(REQ_LOOKUP, ~oldest, '0);
		issue(REQ_WIPE, '0, '0);
		issue(REQ_REGISTER, oldest, 8'hC3);
		issue(REQ_LOOKUP, oldest, '0);
		issue(REQ_POP, '0, '0);
		issue(REQ_LOOKUP, oldest, '0);
		wait_all_results();
	endtask

	// Growth mode leans toward opens and registers so that both stacks fill up.
	task automatic test_random_traffic(input int count, input bit grow);
		int               roll;
		logic [REQ_W-1:0] req;
		for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (grow) begin
				if (roll < 20)      req = REQ_OPEN;
				else if (roll < 75) req = REQ_REGISTER;
				else if (roll < 92) req = REQ_LOOKUP;
				else if (roll < 97) req = REQ_POP;
				else if (roll < 98) req = REQ_WIPE;
				else                req = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
			end else begin
				if (roll < 12)      req = REQ_OPEN;
				else if (roll < 50) req = REQ_REGISTER;
				else if (roll < 78) req = REQ_LOOKUP;
				else if (roll < 90) req = REQ_POP;
				else if (roll < 94) req = REQ_WIPE;
				else if (roll < 97) req = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
				else                req = REQ_W'($urandom_range(0, 7));
			end
			issue(req, pick_key(), KIND_W'($urandom));
		end
		wait_all_results();
	endtask

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				error_count++;
				if (error_count <= MAX_SHOWN)
					$display("%0t: result with no transaction pending", $realtime);
			end else begin
				want = pending_outcomes.pop_front();
				checked_count++;
				status_seen[want.st]++;
				if (want.hit) lookup_hits++;
				if (found !== want.hit || entry_index !== want.idx ||
						found_kind !== want.kind || status !== want.st) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN) begin
						$display("%0t: result %0d expected found=%0b index=%0d kind=%02h st=%0d",
							$realtime, checked_count, want.hit, want.idx, want.kind, want.st);
						$display("%0t: result %0d got      found=%0b index=%0d kind=%02h st=%0d",
							$realtime, checked_count, found, entry_index, found_kind, status);
					end
				end
			end
		end
	end

	// Any cycle with an accepted request or a result counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		for (int i = 0; i < 4; i++) status_seen[i] = 0;
		for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_requests();
		test_scope_limits();
		test_entry_limits();
		test_random_traffic(450, 1'b0);
		test_random_traffic(250, 1'b1);
		test_random_traffic(220, 1'b0);
		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			error_count += pending_outcomes.size();
			$display("%0d results never arrived", pending_outcomes.size());
		end
		$display("%0d transactions, %0d results checked, %0d mismatches, %0d other errors",
			sent_count, checked_count, mismatch_count, error_count);
		$display("hits %0d, entry full %0d, scope full %0d, no scope %0d, peak %0d/%0d",
			lookup_hits, status_seen[ST_ENTRY_FULL], status_seen[ST_SCOPE_FULL],
			status_seen[ST_NO_SCOPE], peak_entries, peak_scopes);
		if (mismatch_count == 0 && error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+sv
sv/sss_pkg.sv
sv/sss_entry_ram.sv
sv/sss_scope_ram.sv
sv/sss_ctrl.sv
sv/scoped_symbol_stack.sv
dv/scoped_symbol_stack_tb.sv
